// ----- design/tcsf_pkg.sv -----
// shared types, constants and helpers for the thruster command block
`timescale 1ns / 1ps

package tcsf_pkg;

   localparam int FRAME_DEPTH_DEFAULT = 10;
   localparam int QUEUE_DEPTH = 2;

   // item kinds
   localparam logic [1:0] MODE_BYTE = 2'd0;
   localparam logic [1:0] MODE_IDLE = 2'd1;
   localparam logic [1:0] MODE_TICK = 2'd2;

   // register indexes
   localparam logic [2:0] REG_SLEW_STEP     = 3'd0;
   localparam logic [2:0] REG_LINK_TIMEOUT  = 3'd1;
   localparam logic [2:0] REG_FRAME_HEADER  = 3'd2;
   localparam logic [2:0] REG_SERVO_OPEN    = 3'd3;
   localparam logic [2:0] REG_SERVO_CLOSE   = 3'd4;

   localparam logic [10:0] WIDTH_MAX     = 11'd1900;
   localparam logic [10:0] WIDTH_MIN     = 11'd1100;
   localparam logic [10:0] WIDTH_NEUTRAL = 11'd1500;
   localparam logic [11:0] MIRROR_SUM    = 12'd3000;
   localparam logic [7:0]  CMD_NEUTRAL   = 8'd100;
   localparam logic [7:0]  CMD_CLAMP     = 8'd200;

   localparam logic [7:0]  SLEW_STEP_RESET    = 8'd10;
   localparam logic [7:0]  LINK_TIMEOUT_RESET = 8'd100;
   localparam logic [7:0]  FRAME_HEADER_RESET = 8'd175;
   localparam logic [11:0] SERVO_OPEN_RESET   = 12'd1200;
   localparam logic [11:0] SERVO_CLOSE_RESET  = 12'd2200;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [10:0] thruster_a_width;
      logic [10:0] thruster_b_width;
      logic [10:0] thruster_c_width;
      logic [10:0] thruster_d_width;
      logic [11:0] servo_width;
      logic        link_lost;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  slew_step;
      logic [7:0]  link_timeout_ticks;
      logic [7:0]  frame_header;
      logic [11:0] servo_open_width;
      logic [11:0] servo_close_width;
   } cfg_type;

   // one control tick handed from front to back
   typedef struct packed {
      logic [3:0][10:0] target;
      logic             grip_open;
      logic             lost;
   } job_type;

   // 1900 - 4c, clamped to 1100..1900 (never above for unsigned c)
   function automatic logic [10:0] target_width(input logic [7:0] c);
      logic [10:0] w;
      if (c > CMD_CLAMP) begin
         w = WIDTH_MIN;
      end else begin
         w = WIDTH_MAX - {1'b0, c, 2'b00};
      end
      return w;
   endfunction

endpackage

// ----- design/tcsf_fifo.sv -----
// small first-in first-out queue of words
`timescale 1ns / 1ps

module tcsf_fifo #(
   parameter int DEPTH = 2,
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] data_in,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] data_out,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign data_out = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= data_in;
      end
   end

endmodule

// ----- design/tcsf_front.sv -----
// front end: frame collection, command decode and link-loss counting
`timescale 1ns / 1ps

module tcsf_front #(
   parameter int FRAME_DEPTH = 10
) (
   input  logic              clock,
   input  logic              reset,
   input  tcsf_pkg::cfg_type cfg,
   input  logic              req_push,
   input  tcsf_pkg::req_type req_data,
   output logic              req_full,
   input  logic              job_full,
   output logic              job_push,
   output tcsf_pkg::job_type job_data
);
   import tcsf_pkg::*;

   localparam int CNT_W = $clog2(FRAME_DEPTH + 1);

   logic [7:0]       buf_ff [FRAME_DEPTH];
   logic [7:0]       buf_in [FRAME_DEPTH];
   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]       cmd_ff [4];
   logic [7:0]       cmd_in [4];
   logic             grip_ff, grip_in;
   logic [7:0]       silence_ff, silence_in;
   logic [8:0]       silence_inc;
   logic             accept;
   logic             lost;

   assign req_full    = job_full;
   assign accept      = req_push & ~job_full;
   assign silence_inc = {1'b0, silence_ff} + 9'd1;

   always_comb begin
      buf_in     = buf_ff;
      count_in   = count_ff;
      cmd_in     = cmd_ff;
      grip_in    = grip_ff;
      silence_in = silence_ff;
      lost       = 1'b0;
      job_push   = 1'b0;
      if (accept) begin
         case (req_data.mode)
            MODE_BYTE: begin
               // bytes past the buffer depth are dropped
               if (count_ff < CNT_W'(FRAME_DEPTH)) begin
                  for (int k = 0; k < FRAME_DEPTH; k++) begin
                     if (count_ff == CNT_W'(k)) begin
                        buf_in[k] = req_data.rx_byte;
                     end
                  end
                  count_in = count_ff + 1'b1;
               end
            end
            MODE_IDLE: begin
               if (buf_ff[0] == cfg.frame_header) begin
                  for (int k = 0; k < 4; k++) begin
                     cmd_in[k] = buf_ff[k + 1];
                  end
                  grip_in = (buf_ff[7] != 8'd0);
               end
               count_in   = '0;
               silence_in = 8'd0;
            end
            MODE_TICK: begin
               job_push = 1'b1;
               if (silence_inc > {1'b0, cfg.link_timeout_ticks}) begin
                  lost = 1'b1;
                  for (int k = 0; k < 4; k++) begin
                     cmd_in[k] = CMD_NEUTRAL;
                  end
                  grip_in    = 1'b0;
                  silence_in = cfg.link_timeout_ticks;
               end else begin
                  silence_in = silence_inc[7:0];
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         job_data.target[k] = target_width(cmd_in[k]);
      end
      job_data.grip_open = grip_in;
      job_data.lost      = lost;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < FRAME_DEPTH; k++) begin
            buf_ff[k] <= 8'd0;
         end
         for (int k = 0; k < 4; k++) begin
            cmd_ff[k] <= CMD_NEUTRAL;
         end
         count_ff   <= '0;
         grip_ff    <= 1'b0;
         silence_ff <= 8'd0;
      end else begin
         buf_ff     <= buf_in;
         cmd_ff     <= cmd_in;
         count_ff   <= count_in;
         grip_ff    <= grip_in;
         silence_ff <= silence_in;
      end
   end

endmodule

// ----- design/tcsf_back.sv -----
// back end: per-tick slew limiting of the four thrusters and result build
`timescale 1ns / 1ps

module tcsf_back (
   input  logic              clock,
   input  logic              reset,
   input  tcsf_pkg::cfg_type cfg,
   input  logic              job_empty,
   input  tcsf_pkg::job_type job_data,
   output logic              job_pop,
   input  logic              rsp_full,
   output logic              rsp_push,
   output tcsf_pkg::rsp_type rsp_data
);
   import tcsf_pkg::*;

   logic [10:0] width_ff [4];
   logic [10:0] width_in [4];
   logic [10:0] slewed [4];
   logic [10:0] diff [4];
   logic        rising [4];
   logic        go;

   assign go       = ~job_empty & ~rsp_full;
   assign job_pop  = go;
   assign rsp_push = go;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         rising[k] = job_data.target[k] > width_ff[k];
         diff[k]   = rising[k] ? job_data.target[k] - width_ff[k]
                               : width_ff[k] - job_data.target[k];
         if (diff[k] > {3'b000, cfg.slew_step}) begin
            slewed[k] = rising[k] ? width_ff[k] + {3'b000, cfg.slew_step}
                                  : width_ff[k] - {3'b000, cfg.slew_step};
         end else begin
            slewed[k] = job_data.target[k];
         end
         width_in[k] = go ? slewed[k] : width_ff[k];
      end
   end

   always_comb begin
      rsp_data.thruster_a_width = slewed[0];
      rsp_data.thruster_b_width = slewed[1];
      // channel four drives the mirrored vertical thruster
      rsp_data.thruster_c_width = 11'(MIRROR_SUM - {1'b0, slewed[3]});
      rsp_data.thruster_d_width = slewed[2];
      rsp_data.servo_width      = job_data.grip_open ? cfg.servo_open_width
                                                     : cfg.servo_close_width;
      rsp_data.link_lost        = job_data.lost;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 4; k++) begin
            width_ff[k] <= WIDTH_NEUTRAL;
         end
      end else begin
         width_ff <= width_in;
      end
   end

endmodule

// ----- design/thruster_command_slew_failsafe.sv -----
// top level: thruster command receiver with slew limiting and link-loss failsafe
`timescale 1ns / 1ps

// Takes one word per clock on the request side while full is low: a received
// byte, a line-idle event that ends a frame, or a control tick. Only a control
// tick produces a result word, carrying the four slewed thruster widths, the
// gripper servo width and the link-lost flag. The front end updates the frame
// buffer, command bytes and link-loss counter in the cycle a word is accepted;
// a tick then passes through a two-entry job queue to the slew stage, which
// writes a two-entry result queue that drives the result ports and waits while
// that queue is full. full rises only when the job queue is full, i.e. when
// results are not being popped. Registers may be written only while the block
// is idle.

module thruster_command_slew_failsafe #(
   parameter int FRAME_DEPTH = tcsf_pkg::FRAME_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tcsf_pkg::req_type req_data,
   output logic              full,
   output logic              empty,
   input  logic              pop,
   output tcsf_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [11:0]       csr_wdata
);
   import tcsf_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    job_push, job_full, job_pop, job_empty;
   job_type job_in, job_out;
   logic    rsp_push, rsp_full;
   rsp_type rsp_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_SLEW_STEP:    cfg_in.slew_step          = csr_wdata[7:0];
            REG_LINK_TIMEOUT: cfg_in.link_timeout_ticks = csr_wdata[7:0];
            REG_FRAME_HEADER: cfg_in.frame_header       = csr_wdata[7:0];
            REG_SERVO_OPEN:   cfg_in.servo_open_width   = csr_wdata;
            REG_SERVO_CLOSE:  cfg_in.servo_close_width  = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slew_step          <= SLEW_STEP_RESET;
         cfg_ff.link_timeout_ticks <= LINK_TIMEOUT_RESET;
         cfg_ff.frame_header       <= FRAME_HEADER_RESET;
         cfg_ff.servo_open_width   <= SERVO_OPEN_RESET;
         cfg_ff.servo_close_width  <= SERVO_CLOSE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tcsf_front #(
      .FRAME_DEPTH (FRAME_DEPTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req_push (push),
      .req_data (req_data),
      .req_full (full),
      .job_full (job_full),
      .job_push (job_push),
      .job_data (job_in)
   );

   tcsf_fifo #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH ($bits(job_type))
   ) u_job_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .data_in  (job_in),
      .full     (job_full),
      .pop      (job_pop),
      .data_out (job_out),
      .empty    (job_empty)
   );

   tcsf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .job_empty (job_empty),
      .job_data  (job_out),
      .job_pop   (job_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp_data  (rsp_in)
   );

   tcsf_fifo #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH ($bits(rsp_type))
   ) u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (rsp_push),
      .data_in  (rsp_in),
      .full     (rsp_full),
      .pop      (pop),
      .data_out (rsp_data),
      .empty    (empty)
   );

endmodule
